// ===== rtl/core/tlpq_pkg.sv =====
// shared types and constants of the two-level priority queue
`default_nettype none
package tlpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int ENTRY_W         = 41;

    // op codes
    localparam logic [2:0] OP_ENQ     = 3'd0;
    localparam logic [2:0] OP_DEQ     = 3'd1;
    localparam logic [2:0] OP_SERVE   = 3'd2;
    localparam logic [2:0] OP_PROMOTE = 3'd3;
    localparam logic [2:0] OP_ALL     = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOTF  = 2'd3;

    // configuration register indexes
    localparam logic REG_AGE_THR = 1'b0;
    localparam logic REG_BATCH   = 1'b1;

    localparam logic [6:0] RST_AGE_THR = 7'd60;
    localparam logic [3:0] RST_BATCH   = 4'd5;
    localparam logic [3:0] MAX_BATCH   = 4'd8;

    typedef struct packed {
        logic [15:0] ticket;
        logic [6:0]  age;
        logic        hw;
        logic        prio;
        logic [15:0] reg_time;
    } t_entry;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] ticket;
        logic [6:0]  age;
        logic        health_worker;
        logic [15:0] reg_time;
    } t_in_word;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] out_ticket;
        logic [6:0]  out_age;
        logic        out_health_worker;
        logic        out_priority;
        logic [15:0] out_reg_time;
        logic [4:0]  occupancy;
        logic [1:0]  status;
        logic        last;
    } t_out_word;

endpackage
`default_nettype wire

// ===== rtl/core/tlpq_mem.sv =====
// entry store: one write port, one registered read port
`default_nettype none
module tlpq_mem
    import tlpq_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/core/two_level_priority_queue_top.sv =====
// Two-level priority queue. Entries sit in a circular buffer memory addressed from a
// head pointer; dequeue and serve pop entries from the head one at a time. Enqueue of a
// non-priority entry writes it at the tail; a priority enqueue scans the leading priority
// run and then shifts the tail down one place, one entry at a time, before writing the
// new entry. Promote by ticket scans for the ticket and shifts the entries before it the
// same way. Promote all rewrites every held entry. All of these share the single
// read-modify-write path through the entry memory; one word is handled at a time, and
// the input is ready again as soon as the last result word is in the output register.
`default_nettype none
module two_level_priority_queue_top
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_word   i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_SH_RD    = 4'd3;
    localparam logic [3:0] S_SH_WR    = 4'd4;
    localparam logic [3:0] S_INS      = 4'd5;
    localparam logic [3:0] S_POP_RD   = 4'd6;
    localparam logic [3:0] S_POP_OUT  = 4'd7;
    localparam logic [3:0] S_ALL_RD   = 4'd8;
    localparam logic [3:0] S_ALL_WR   = 4'd9;
    localparam logic [3:0] S_RESP     = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [6:0]    r_age_thr;
    logic [3:0]    r_batch;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_lo, n_lo;
    logic [3:0]    r_left, n_left;
    logic          r_enq, n_enq;
    logic [15:0]   r_tk, n_tk;
    t_entry        r_ent, n_ent;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata, mem_rdata;

    // logical position to memory address, wrapped
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(l);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return AW'(sum);
    endfunction

    tlpq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic slot_free;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_thr <= RST_AGE_THR;
            r_batch   <= RST_BATCH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AGE_THR: r_age_thr <= i_cfg_data;
                REG_BATCH:   r_batch   <= i_cfg_data[3:0];
                default:     r_batch   <= r_batch;
            endcase
        end
    end

    // sequencer
    always_comb begin
        t_entry      e;
        logic        hit;
        logic [3:0]  bs;
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_left      = r_left;
        n_enq       = r_enq;
        n_tk        = r_tk;
        n_ent       = r_ent;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_ent;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        e           = mem_rdata;
        hit         = 1'b0;
        bs          = (r_batch == 4'd0) ? 4'd1 : ((r_batch > MAX_BATCH) ? MAX_BATCH : r_batch);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_tk     = i_in.ticket;
                    n_idx    = '0;
                    case (i_in.op)
                        OP_ENQ: begin
                            n_ent.ticket   = i_in.ticket;
                            n_ent.age      = i_in.age;
                            n_ent.hw       = i_in.health_worker;
                            n_ent.reg_time = i_in.reg_time;
                            n_ent.prio     = (i_in.age >= r_age_thr) || i_in.health_worker;
                            n_enq          = 1'b1;
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else if (n_ent.prio) begin
                                n_state = S_SCAN_RD;
                            end else begin
                                n_lo    = r_count;
                                n_state = S_INS;
                            end
                        end
                        OP_DEQ, OP_SERVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_left = (i_in.op == OP_DEQ) ? 4'd1 : bs;
                                if (CW'(n_left) > r_count) begin
                                    n_left = 4'(r_count);
                                end
                                n_state = S_POP_RD;
                            end
                        end
                        OP_PROMOTE: begin
                            n_enq   = 1'b0;
                            n_state = S_SCAN_RD;
                        end
                        OP_ALL:  n_state = S_ALL_RD;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            // scan from the head
            S_SCAN_RD: begin
                if (r_idx == r_count) begin
                    if (r_enq) begin
                        n_lo    = r_count;
                        n_state = S_INS;
                    end else begin
                        n_status = ST_NOTF;
                        n_state  = S_RESP;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(r_head, r_idx);
                    n_state   = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                hit = r_enq ? !mem_rdata.prio : (mem_rdata.ticket == r_tk);
                if (hit) begin
                    if (r_enq) begin
                        n_lo  = r_idx;
                        n_idx = r_count;
                    end else begin
                        e.prio = 1'b1;
                        n_ent  = e;
                        n_lo   = '0;
                    end
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            // move entries one place toward the tail
            S_SH_RD: begin
                if (r_idx == r_lo) begin
                    n_state = S_INS;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(r_head, r_idx - 1'b1);
                    n_state   = S_SH_WR;
                end
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_idx);
                mem_wdata = mem_rdata;
                n_idx     = r_idx - 1'b1;
                n_state   = S_SH_RD;
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_lo);
                mem_wdata = r_ent;
                if (r_enq) begin
                    n_count = r_count + 1'b1;
                end
                n_state = S_RESP;
            end
            // pop the head
            S_POP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_head;
                n_state   = S_POP_OUT;
            end
            S_POP_OUT: begin
                if (slot_free) begin
                    n_count                 = r_count - 1'b1;
                    n_head                  = phys(r_head, CW'(1));
                    n_left                  = r_left - 1'b1;
                    n_out_valid             = 1'b1;
                    n_out.valid_res         = 1'b1;
                    n_out.out_ticket        = mem_rdata.ticket;
                    n_out.out_age           = mem_rdata.age;
                    n_out.out_health_worker = mem_rdata.hw;
                    n_out.out_priority      = mem_rdata.prio;
                    n_out.out_reg_time      = mem_rdata.reg_time;
                    n_out.occupancy         = 5'(n_count);
                    n_out.status            = ST_OK;
                    n_out.last              = (r_left == 4'd1);
                    n_state                 = (r_left == 4'd1) ? S_IDLE : S_POP_RD;
                end
            end
            // mark every entry priority
            S_ALL_RD: begin
                if (r_idx == r_count) begin
                    n_state = S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(r_head, r_idx);
                    n_state   = S_ALL_WR;
                end
            end
            S_ALL_WR: begin
                e.prio    = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_idx);
                mem_wdata = e;
                n_idx     = r_idx + 1'b1;
                n_state   = S_ALL_RD;
            end
            // status-only result word
            S_RESP: begin
                if (slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.occupancy = 5'(r_count);
                    n_out.status    = r_status;
                    n_out.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers and output word
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_left   <= n_left;
        r_enq    <= n_enq;
        r_tk     <= n_tk;
        r_ent    <= n_ent;
        r_status <= n_status;
        r_out    <= n_out;
    end
endmodule
`default_nettype wire
